>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
// They expect a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A condition that, once seen, forces another one in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/olar_pkg.sv
// Package of the ordered list block: sizes, command codes and the cell control word.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package olar_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 16;

  // Fixed widths of the word fields.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int CNTF_W  = 5;

  // Width of the entry count and of the compare arithmetic.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Control word that the top level hands to each cell of the row.
  typedef struct packed {
    logic append_here;  // take the appended value
    logic shift_in;     // take the value of the right-hand neighbour
    logic pick;         // present the stored value on the removal tap
  } olar_ctrl_t;

  // Reduces the entry count to the five-bit result field.
  function automatic logic [CNTF_W-1:0] cnt_to_field(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[CNTF_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/olar_cmd_if.sv
// Command channel of the ordered list block: valid/ready handshake and command word.
// Depends on olar_pkg.
`default_nettype none

interface olar_cmd_if;
  import olar_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [VALUE_W-1:0] value;
  logic        [POS_W-1:0]   position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

`default_nettype wire

>>> rtl/core/olar_res_if.sv
// Result channel of the ordered list block: valid/ready handshake and result word.
// Depends on olar_pkg.
`default_nettype none

interface olar_res_if;
  import olar_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic                      found;
  logic                      refused_full;
  logic        [CNTF_W-1:0]  entry_count;

  modport source (output valid, removed_value, found, refused_full, entry_count,
                  input ready);
  modport sink   (input valid, removed_value, found, refused_full, entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/olar_cell.sv
// One storage cell of the list row: holds a single entry and trades it with its neighbour.
// Depends on olar_pkg.
`default_nettype none

module olar_cell (
  input  logic                          clk,
  input  olar_pkg::olar_ctrl_t          ctrl,
  input  logic [olar_pkg::VALUE_W-1:0]  append_data,
  input  logic [olar_pkg::VALUE_W-1:0]  right_data,
  output logic [olar_pkg::VALUE_W-1:0]  data,
  output logic [olar_pkg::VALUE_W-1:0]  tap
);
  import olar_pkg::*;

  // The stored entry takes either a new tail value or the entry to its right.
  always_ff @(posedge clk) begin
    if (ctrl.append_here) begin
      data <= append_data;
    end else if (ctrl.shift_in) begin
      data <= right_data;
    end
  end

  // The removal tap is zero unless this cell holds the entry being removed.
  assign tap = ctrl.pick ? data : '0;

endmodule

`default_nettype wire

>>> rtl/core/ordered_list_append_remove_at.sv
// Top level of the ordered list block: command decode, entry count, cell row, result register.
// Depends on olar_pkg, olar_cmd_if, olar_res_if and olar_cell.
//
// Use of the block:
//   cmd carries one command word: append value at the tail, or remove the entry at a
//   1-based position. res returns exactly one result word per command: the removed
//   value with found, the refused_full flag for an append to a full list, and the
//   number of entries after the command.
//   The result word is registered and valid in the cycle after the command word is accepted.
//   Throughput: one command per cycle unless the receiver stalls. Every cell of the row
//   updates in the same cycle, so a remove closes the gap at once and the next command sees the new list.
//   The result register decouples the two sides: cmd.ready is high whenever the
//   result register is empty or is being emptied in the same cycle.
//   When the receiver stalls, the result word holds and no further command is
//   accepted until it is taken.
//   Reset (rst, synchronous, active high) empties the list and the result register.
//   Entry storage is not cleared; only entries below the count are ever read.
//   A remove at position 0 or beyond the count, or on an empty list, changes nothing
//   and returns found low with a zero value.
`default_nettype none

module ordered_list_append_remove_at (
  input  logic      clk,
  input  logic      rst,
  olar_cmd_if.sink  cmd,
  olar_res_if.source res
);
  import olar_pkg::*;

  // Entry count and result register.
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               res_valid;
  logic [VALUE_W-1:0] res_value;
  logic               res_found;
  logic               res_full;
  logic [CNTF_W-1:0]  res_count;

  // Decode of the current command.
  logic               accept;
  logic               is_remove;
  logic [CMP_W-1:0]   count_w;
  logic [CMP_W-1:0]   pos_w;
  logic [CMP_W-1:0]   rm_idx;
  logic               full;
  logic               hit;
  logic               do_append;
  logic               do_remove;
  logic [VALUE_W-1:0] removed;

  // Cell row wiring.
  olar_ctrl_t         ctrl [CAPACITY];
  logic [VALUE_W-1:0] cell_data [CAPACITY];
  logic [VALUE_W-1:0] cell_tap [CAPACITY];

  // A new word is taken whenever the result register is free or being drained.
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_remove = (cmd.command == CMD_REMOVE);

  assign count_w   = CMP_W'(count);
  assign pos_w     = CMP_W'(cmd.position);
  assign rm_idx    = pos_w - CMP_W'(1);
  assign full      = (count_w == CMP_W'(CAPACITY));
  assign hit       = (pos_w != '0) && (pos_w <= count_w);
  assign do_append = accept && !is_remove && !full;
  assign do_remove = accept && is_remove && hit;

  // Each cell learns from its index whether it appends, shifts or is removed.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

    assign ctrl[i].append_here = do_append && (count_w == IDX);
    assign ctrl[i].shift_in    = do_remove && (IDX >= rm_idx) && ((IDX + CMP_W'(1)) < count_w);
    assign ctrl[i].pick        = do_remove && (IDX == rm_idx);

    if (i == CAPACITY - 1) begin : g_last
      olar_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .append_data (cmd.value),
        .right_data  ({VALUE_W{1'b0}}),
        .data        (cell_data[i]),
        .tap         (cell_tap[i])
      );
    end else begin : g_mid
      olar_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl[i]),
        .append_data (cmd.value),
        .right_data  (cell_data[i+1]),
        .data        (cell_data[i]),
        .tap         (cell_tap[i])
      );
    end
  end

  // Only the removed cell drives its tap, so the taps are merged by OR.
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_tap[i];
    end
  end

  // Next entry count.
  always_comb begin
    priority if (do_append) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_value <= removed;
      res_found <= do_remove;
      res_full  <= !is_remove && full;
      res_count <= cnt_to_field(count_next);
    end
  end

  assign res.valid         = res_valid;
  assign res.removed_value = res_value;
  assign res.found         = res_found;
  assign res.refused_full  = res_full;
  assign res.entry_count   = res_count;

endmodule

`default_nettype wire

>>> rtl/core/olar_checker.sv
// Port-level checks of the ordered list block, bound to its top level.
// Depends on olar_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module olar_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [olar_pkg::VALUE_W-1:0]  removed_value,
  input logic                          found,
  input logic                          refused_full,
  input logic [olar_pkg::CNTF_W-1:0]   entry_count
);
  import olar_pkg::*;

  // A result word is either a hit, a refusal or neither, never both.
  `ASSERT_ALWAYS(a_found_xor_full, !(res_valid && found && refused_full), "found and refused_full both set")

  // Nothing removed means a zero value.
  `ASSERT_ALWAYS(a_zero_on_miss, !(res_valid && !found && (removed_value != '0)), "value without found")

  // A refused append reports a full list.
  `ASSERT_ALWAYS(a_full_count, !(res_valid && refused_full && (entry_count != CNTF_W'(CAPACITY))), "refusal below capacity")

  // A stalled result word holds.
  `ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(removed_value) && $stable(entry_count), "stalled result changed")

endmodule

bind ordered_list_append_remove_at olar_checker u_olar_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .removed_value (res.removed_value),
  .found         (res.found),
  .refused_full  (res.refused_full),
  .entry_count   (res.entry_count)
);

`default_nettype wire
